@@ design/assert_macros.svh @@
// Assertion macros used by the RTL (included by shk_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/shk_pkg.sv @@
// Package: shortcut tokenizer constants, keyword tables, event type and match functions
`timescale 1ns / 1ps
package shk_pkg;

  localparam int TOKEN_MAX_CHARS = 9;
  localparam int KEY_SLOT_LIMIT  = 6;
  localparam int SLOT_N          = 6;
  localparam int QUEUE_DEPTH     = 2;
  localparam int TOK_W           = 8 * TOKEN_MAX_CHARS;
  localparam int LEN_W           = $clog2(TOKEN_MAX_CHARS + 1);
  localparam int CNT_W           = 3;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] KEY_A      = 8'h04;
  localparam logic [7:0] KEY_1      = 8'h1E;
  localparam logic [7:0] KEY_0      = 8'h27;

  localparam int MOD_N = 14;
  localparam int KEY_N = 19;

  localparam logic [TOK_W-1:0] MOD_TEXT [MOD_N] = '{
    "ctrl", "control", "shift", "alt", "option", "cmd", "gui", "win",
    "rctrl", "rshift", "ralt", "rcmd", "rgui", "rwin"};
  localparam int MOD_LEN [MOD_N] = '{4, 7, 5, 3, 6, 3, 3, 3, 5, 6, 4, 4, 4, 4};
  localparam logic [7:0] MOD_CODE [MOD_N] = '{
    8'h01, 8'h01, 8'h02, 8'h04, 8'h04, 8'h08, 8'h08, 8'h08,
    8'h10, 8'h20, 8'h40, 8'h80, 8'h80, 8'h80};

  localparam logic [TOK_W-1:0] KEY_TEXT [KEY_N] = '{
    "return", "enter", "escape", "esc", "backspace", "tab", "space",
    "f1", "f2", "f3", "f4", "f5", "f6", "f7", "f8", "f9", "f10", "f11", "f12"};
  localparam int KEY_LEN [KEY_N] = '{6, 5, 6, 3, 9, 3, 5,
    2, 2, 2, 2, 2, 2, 2, 2, 2, 3, 3, 3};
  localparam logic [7:0] KEY_CODE [KEY_N] = '{
    8'h28, 8'h28, 8'h29, 8'h29, 8'h2A, 8'h2B, 8'h2C,
    8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42,
    8'h43, 8'h44, 8'h45};

  typedef struct packed {
    logic [TOK_W-1:0] text;
    logic [LEN_W-1:0] len;
    logic             skip;
    logic             rej;
    logic             is_end;
  } tok_evt_t;

  function automatic logic [7:0] mod_match(input logic [TOK_W-1:0] text,
                                           input logic [LEN_W-1:0] len);
    logic [7:0] res;
    res = 8'h00;
    for (int i = 0; i < MOD_N; i++) begin
      if (len == LEN_W'(MOD_LEN[i]) && text == MOD_TEXT[i]) res = res | MOD_CODE[i];
    end
    return res;
  endfunction

  function automatic logic [7:0] key_match(input logic [TOK_W-1:0] text,
                                           input logic [LEN_W-1:0] len);
    logic [7:0] res;
    logic [7:0] c;
    res = 8'h00;
    c = text[7:0];
    if (len == LEN_W'(1)) begin
      if (c >= CHAR_LA && c <= CHAR_LZ) res = KEY_A + (c - CHAR_LA);
      else if (c >= CHAR_ONE && c <= CHAR_NINE) res = KEY_1 + (c - CHAR_ONE);
      else if (c == CHAR_ZERO) res = KEY_0;
    end else begin
      for (int i = 0; i < KEY_N; i++) begin
        if (len == LEN_W'(KEY_LEN[i]) && text == KEY_TEXT[i]) res = res | KEY_CODE[i];
      end
    end
    return res;
  endfunction

endpackage

@@ design/shk_if.sv @@
// Channel interfaces: character input and keyboard report output
`timescale 1ns / 1ps
interface shk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       char_valid;
  logic       end_of_string;
  modport source (output valid, char_byte, char_valid, end_of_string, input ready);
  modport sink (input valid, char_byte, char_valid, end_of_string, output ready);
endinterface

interface shk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] key_slot_one;
  logic [7:0] key_slot_two;
  logic [7:0] key_slot_three;
  logic [7:0] key_slot_four;
  logic [7:0] key_slot_five;
  logic [7:0] key_slot_six;
  logic [2:0] keys_placed;
  logic [7:0] rejected_tokens;
  modport source (output valid, modifier_bits, key_slot_one, key_slot_two, key_slot_three,
                  key_slot_four, key_slot_five, key_slot_six, keys_placed,
                  rejected_tokens, input ready);
  modport sink (input valid, modifier_bits, key_slot_one, key_slot_two, key_slot_three,
                key_slot_four, key_slot_five, key_slot_six, keys_placed,
                rejected_tokens, output ready);
endinterface

@@ design/shortcut_text_to_hid_report_top.sv @@
// Shortcut text to keyboard report: top level
//
// in_ch carries one character a cycle (char_byte, char_valid) with end_of_string
// on the last item; a transfer happens when valid and ready are both high.
// Plus signs split the text into tokens; each token is trimmed, lowercased
// and matched against modifier and key names. At end_of_string one report
// leaves on out_ch: modifier bits, six key slots, keys_placed, rejected_tokens.
// Throughput: one character per cycle while out_ch keeps taking reports,
// including back-to-back strings; the front tokenizer, a two-entry event queue
// and the matching back end each take one item per cycle in that case.
// The end_of_string event goes through the event queue and is then loaded
// into the output register, from which the report is valid on out_ch.
// When out_ch stalls, the report is held in the output register; the back end
// keeps absorbing tokens and the queue fills only if a second report waits,
// after which in_ch.ready drops until out_ch drains.
// Reset (rst_n low, synchronous) empties the queue, drops any pending report
// and clears the token and all accumulators.
`timescale 1ns / 1ps
module shortcut_text_to_hid_report_top import shk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  shk_in_if.sink    in_ch,
  shk_out_if.source out_ch
);

  logic     q_push, q_ready, q_pop, head_valid;
  tok_evt_t q_evt, head_evt;

  shk_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_evt   (q_evt)
  );

  shk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_evt   (q_evt),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_evt   (head_evt)
  );

  shk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_evt   (head_evt),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

@@ design/shk_front.sv @@
// Front end: accepts characters, builds the trimmed lowercase token, emits token events
`timescale 1ns / 1ps
module shk_front import shk_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  shk_in_if.sink        in_ch,
  input  logic          q_ready,
  output logic          q_push,
  output tok_evt_t      q_evt
);

  logic [TOK_W-1:0] tok_r, tok_nxt, tok_post;
  logic [LEN_W-1:0] len_r, len_nxt, len_post;
  logic             broken_r, broken_nxt, broken_post;
  logic             trail_r, trail_nxt, trail_post;
  logic             acc, is_plus, is_sp, plus_close;
  logic [7:0]       lc;

  assign in_ch.ready = q_ready;
  assign acc         = in_ch.valid && q_ready;
  assign is_plus     = in_ch.char_byte == CHAR_PLUS;
  assign is_sp       = in_ch.char_byte == CHAR_SPACE ||
                       (in_ch.char_byte >= CHAR_TAB && in_ch.char_byte <= CHAR_CR);
  assign plus_close  = in_ch.char_valid && is_plus;
  assign lc          = (in_ch.char_byte >= CHAR_UA && in_ch.char_byte <= CHAR_UZ) ?
                       in_ch.char_byte + CASE_DELTA : in_ch.char_byte;

  always_comb begin
    tok_post    = tok_r;
    len_post    = len_r;
    broken_post = broken_r;
    trail_post  = trail_r;
    if (plus_close) begin
      tok_post    = '0;
      len_post    = '0;
      broken_post = 1'b0;
      trail_post  = 1'b0;
    end else if (in_ch.char_valid) begin
      if (is_sp) begin
        trail_post = 1'b1;
      end else if (!broken_r) begin
        if (len_r != '0 && trail_r) begin
          broken_post = 1'b1;
        end else begin
          trail_post = 1'b0;
          if (len_r >= LEN_W'(TOKEN_MAX_CHARS)) begin
            broken_post = 1'b1;
          end else begin
            tok_post = {tok_r[TOK_W-9:0], lc};
            len_post = len_r + LEN_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    q_push = acc && (plus_close || in_ch.end_of_string);
    if (plus_close) begin
      q_evt.text = tok_r;
      q_evt.len  = len_r;
      q_evt.skip = !(len_r != '0 || trail_r || broken_r);
      q_evt.rej  = broken_r || len_r == '0;
    end else begin
      q_evt.text = tok_post;
      q_evt.len  = len_post;
      q_evt.skip = !(len_post != '0 || trail_post || broken_post);
      q_evt.rej  = broken_post || len_post == '0;
    end
    q_evt.is_end = in_ch.end_of_string;
  end

  always_comb begin
    tok_nxt    = tok_r;
    len_nxt    = len_r;
    broken_nxt = broken_r;
    trail_nxt  = trail_r;
    if (acc) begin
      if (in_ch.end_of_string) begin
        tok_nxt    = '0;
        len_nxt    = '0;
        broken_nxt = 1'b0;
        trail_nxt  = 1'b0;
      end else begin
        tok_nxt    = tok_post;
        len_nxt    = len_post;
        broken_nxt = broken_post;
        trail_nxt  = trail_post;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= '0;
      len_r    <= '0;
      broken_r <= 1'b0;
      trail_r  <= 1'b0;
    end else begin
      tok_r    <= tok_nxt;
      len_r    <= len_nxt;
      broken_r <= broken_nxt;
      trail_r  <= trail_nxt;
    end
  end

endmodule

@@ design/shk_queue.sv @@
// Short queue of token events between front and back
`timescale 1ns / 1ps
module shk_queue import shk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tok_evt_t push_evt,
  output logic     push_ready,
  input  logic     pop,
  output logic     head_valid,
  output tok_evt_t head_evt
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  tok_evt_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] cnt_r, cnt_nxt;

  assign push_ready = cnt_r != CNT_QW'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_evt   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CNT_QW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_QW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_evt;
  end

endmodule

@@ design/shk_back.sv @@
// Back end: matches tokens, accumulates modifiers, key slots and rejects, registers the report
`timescale 1ns / 1ps
`include "assert_macros.svh"
module shk_back import shk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  tok_evt_t  head_evt,
  output logic      pop,
  shk_out_if.source out_ch
);

  logic [7:0]       mod_r, mod_nxt;
  logic [7:0]       slots_r [SLOT_N];
  logic [7:0]       slots_nxt [SLOT_N];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       rej_r, rej_nxt;
  logic             out_valid_r, out_valid_nxt, out_free, load;
  logic [7:0]       o_mod_r, o_rej_r;
  logic [7:0]       o_slots_r [SLOT_N];
  logic [CNT_W-1:0] o_cnt_r;
  logic [7:0]       m, k;
  logic             do_rej, do_place;

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = head_valid && (!head_evt.is_end || out_free);
  assign load     = pop && head_evt.is_end;
  assign m        = mod_match(head_evt.text, head_evt.len);
  assign k        = key_match(head_evt.text, head_evt.len);

  always_comb begin
    do_rej   = 1'b0;
    do_place = 1'b0;
    mod_nxt  = mod_r;
    if (!head_evt.skip) begin
      if (head_evt.rej) begin
        do_rej = 1'b1;
      end else if (m != 8'h00) begin
        mod_nxt = mod_r | m;
      end else if (k != 8'h00 && cnt_r < CNT_W'(KEY_SLOT_LIMIT)) begin
        do_place = 1'b1;
      end else begin
        do_rej = 1'b1;
      end
    end
    for (int i = 0; i < SLOT_N; i++) begin
      slots_nxt[i] = (do_place && cnt_r == CNT_W'(i)) ? k : slots_r[i];
    end
    cnt_nxt = do_place ? cnt_r + CNT_W'(1) : cnt_r;
    rej_nxt = (do_rej && rej_r != 8'hFF) ? rej_r + 8'd1 : rej_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= '0;
      cnt_r       <= '0;
      rej_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_N; i++) slots_r[i] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (head_evt.is_end) begin
          mod_r <= '0;
          cnt_r <= '0;
          rej_r <= '0;
          for (int i = 0; i < SLOT_N; i++) slots_r[i] <= '0;
        end else begin
          mod_r <= mod_nxt;
          cnt_r <= cnt_nxt;
          rej_r <= rej_nxt;
          for (int i = 0; i < SLOT_N; i++) slots_r[i] <= slots_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_mod_r <= mod_nxt;
      o_cnt_r <= cnt_nxt;
      o_rej_r <= rej_nxt;
      for (int i = 0; i < SLOT_N; i++) o_slots_r[i] <= slots_nxt[i];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.modifier_bits   = o_mod_r;
  assign out_ch.key_slot_one    = o_slots_r[0];
  assign out_ch.key_slot_two    = o_slots_r[1];
  assign out_ch.key_slot_three  = o_slots_r[2];
  assign out_ch.key_slot_four   = o_slots_r[3];
  assign out_ch.key_slot_five   = o_slots_r[4];
  assign out_ch.key_slot_six    = o_slots_r[5];
  assign out_ch.keys_placed     = o_cnt_r;
  assign out_ch.rejected_tokens = o_rej_r;

  `ASSERT_ALWAYS(a_slot_bound, clk, rst_n, cnt_r <= CNT_W'(KEY_SLOT_LIMIT), "slot count past limit")
  `ASSERT_NEXT(a_clear_after_report, clk, rst_n, load, cnt_r == '0 && rej_r == '0 && mod_r == '0, "accumulators not cleared after report")
  `ASSERT_NEXT(a_out_only_on_load, clk, rst_n, !out_valid_r && !load, !out_valid_r, "report shown without load")

endmodule
